/* sv/otfs_pkg.sv */
// Shared types and constants for the OXM TLV field strip block.
// No dependencies; imported by every module of the block.

package otfs_pkg;

	localparam int unsigned CMD_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 4;

	localparam logic [16:0] MATCH_HEAD_BYTES = 17'd4;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// One entry of the work queue between front and back.
	typedef struct packed {
		logic [3:0][7:0] bytes;     // header bytes, or a lone payload byte in bytes[3]
		logic            has_hdr;   // emit all four header bytes
		logic            has_byte;  // emit bytes[3]
		logic            has_len;   // emit the length item after the data
		logic [15:0]     len;
		logic            trunc;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic [15:0] out_value;
		logic        is_length;
		logic        run_last;
		logic        truncated;
	} item_t;

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [16:0] b);
		logic [16:0] s;
		s = {1'b0, a} + b;
		return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[15:0];
	endfunction

endpackage

/* sv/otfs_queue.sv */
// Small register queue with push/full and pop/empty sides.
// Uses otfs_pkg only for the default DEPTH (CMD_DEPTH_DEF).

module otfs_queue import otfs_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = CMD_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* sv/otfs_front.sv */
// Front end: takes one byte per beat, tracks TLV framing and the kept count,
// and turns each byte into a work command. Depends on otfs_pkg.

module otfs_front import otfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       cfg_we,
	input  logic [6:0] cfg_field,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [6:0]  target_q;
	logic [7:0]  hold_q [3];
	logic [1:0]  hdr_cnt_q;
	logic [7:0]  pl_left_q;
	logic        dropping_q;
	logic [15:0] kept_q;

	logic        in_payload, hdr_done, drop_now;
	logic        emit_byte, emit_hdr;
	logic [15:0] kept_n;
	logic [1:0]  hdr_cnt_n;
	logic [7:0]  pl_left_n;

	always_comb begin
		in_payload = (pl_left_q != '0);
		hdr_done   = !in_payload && (hdr_cnt_q == 2'd3);
		drop_now   = (hold_q[2][7:1] == target_q);
		emit_byte  = in_payload && !dropping_q;
		emit_hdr   = hdr_done && !drop_now;

		kept_n = kept_q;
		if (emit_byte) begin
			kept_n = sat_add(kept_q, 17'd1);
		end else if (emit_hdr) begin
			kept_n = sat_add(kept_q, 17'd4);
		end

		hdr_cnt_n = hdr_cnt_q;
		pl_left_n = pl_left_q;
		if (in_payload) begin
			pl_left_n = pl_left_q - 8'd1;
		end else if (hdr_done) begin
			hdr_cnt_n = '0;
			pl_left_n = data_byte;
		end else begin
			hdr_cnt_n = hdr_cnt_q + 2'd1;
		end

		cmd.bytes    = emit_hdr ? {hold_q[0], hold_q[1], hold_q[2], data_byte}
		                        : {data_byte, 24'd0};
		cmd.has_hdr  = emit_hdr;
		cmd.has_byte = emit_byte;
		cmd.has_len  = last_byte;
		cmd.len      = sat_add(kept_n, MATCH_HEAD_BYTES);
		cmd.trunc    = (hdr_cnt_n != '0) || (pl_left_n != '0);
		cmd_push     = accept && (emit_byte || emit_hdr || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			hdr_cnt_q  <= '0;
			pl_left_q  <= '0;
			dropping_q <= 1'b0;
			kept_q     <= '0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_field;
			end
			if (accept) begin
				if (last_byte) begin
					hdr_cnt_q  <= '0;
					pl_left_q  <= '0;
					dropping_q <= 1'b0;
					kept_q     <= '0;
				end else begin
					hdr_cnt_q <= hdr_cnt_n;
					pl_left_q <= pl_left_n;
					kept_q    <= kept_n;
					if (hdr_done) begin
						dropping_q <= drop_now;
					end
				end
			end
		end
	end

	// Hold header bytes 0..2; byte 3 is the current beat when the header closes.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (accept && !in_payload && (hdr_cnt_q == 2'(i))) begin
				hold_q[i] <= data_byte;
			end
		end
	end

endmodule

/* sv/otfs_back.sv */
// Back end: expands one work command into its result beats, one per cycle while the
// work queue holds a command and the result queue has room. Depends on otfs_pkg.

module otfs_back import otfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  logic  cmd_empty,
	output logic  cmd_pop,
	input  logic  out_full,
	output logic  item_push,
	output item_t item
);

	logic [2:0] idx_q;
	logic [2:0] n_data, total;
	logic       go, at_end;

	always_comb begin
		n_data = cmd.has_hdr ? 3'd4 : (cmd.has_byte ? 3'd1 : 3'd0);
		total  = n_data + {2'b0, cmd.has_len};
		go     = !cmd_empty && !out_full;
		at_end = (idx_q == total - 3'd1);

		if (idx_q < n_data) begin
			item.out_value = {8'd0, cmd.bytes[2'(3'd3 - idx_q)]};
			item.is_length = 1'b0;
			item.truncated = 1'b0;
		end else begin
			item.out_value = cmd.len;
			item.is_length = 1'b1;
			item.truncated = cmd.trunc;
		end
		item.run_last = at_end;

		item_push = go;
		cmd_pop   = go && at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (go) begin
			idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

/* sv/oxm_tlv_field_strip.sv */
// Top level of the OXM TLV field strip: front, work queue, back, result queue.
// Depends on otfs_pkg, otfs_front, otfs_queue, otfs_back.
//
//  channel   handshake            payload
//  input     push / full          data_byte[7:0], last_byte
//  result    pop / empty          out_value[15:0], is_length, run_last, truncated
//  config    cfg_valid/cfg_ready  target_field[6:0] (cfg_ready is always high)
//
// One byte is accepted per cycle while full is low; the back end drains one result
// beat per cycle while the result queue has room. A kept header yields four beats
// in one go, absorbed by the work and result queues; full rises only when the work
// queue is full.
// arst_n clears framing state, counters, target_field and both queues.

module oxm_tlv_field_strip import otfs_pkg::*; #(
	parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] out_value,
	output logic        is_length,
	output logic        run_last,
	output logic        truncated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  target_field
);

	logic  accept, cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic  out_full, item_push;
	cmd_t  cmd_in, cmd_out;
	item_t item_in, item_out;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;
	assign accept    = push && !cmd_full;

	otfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_field (target_field),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	otfs_queue #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	otfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.item_push (item_push),
		.item      (item_in)
	);

	otfs_queue #(.WIDTH($bits(item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_push),
		.wdata  (item_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (item_out),
		.empty  (empty)
	);

	assign out_value = item_out.out_value;
	assign is_length = item_out.is_length;
	assign run_last  = item_out.run_last;
	assign truncated = item_out.truncated;

endmodule

/* tb/tb_oxm_tlv_field_strip.sv */
// Self-checking bench for oxm_tlv_field_strip: directed rows, then random phases.
// Depends on otfs_pkg (item_t) and the oxm_tlv_field_strip top level.

module tb_oxm_tlv_field_strip;
	import otfs_pkg::*;

	typedef struct packed {
		logic [7:0]  b;
		logic        last;
		logic        chk;     // typed length beat expected for this byte
		logic [15:0] len;
		logic        trunc;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] out_value;
	logic        is_length;
	logic        run_last;
	logic        truncated;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  target_field = 7'd0;

	// sideband that travels with each byte: typed expectation for the directed rows
	logic        dir_chk = 1'b0;
	logic [15:0] dir_len = 16'd0;
	logic        dir_trunc = 1'b0;

	int          errors = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	logic [6:0]  cur_target = 7'd0;
	logic [7:0]  list_bytes [$];

	// shadow of the block's framing state
	logic [7:0]  hold_hdr [4] = '{default: 8'h00};
	logic [2:0]  hdr_seen = 3'd0;
	logic [7:0]  payload_rem = 8'd0;
	logic        skipping = 1'b0;
	logic [15:0] kept_total = 16'd0;
	logic [6:0]  strip_field = 7'd0;
	item_t       step_beats [$];
	item_t       beats_due [$];

	dir_row_t dir_rows [0:25] = '{
		// lone byte, list ends inside a header
		'{8'h00, 1'b1, 1'b1, 16'd4, 1'b1},
		// field 0 with mask bit, removed along with its payload
		'{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'hAA, 1'b1, 1'b1, 16'd4, 1'b0},
		// kept zero-length TLV, then a kept TLV with extreme payload bytes
		'{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'hFE, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h80, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h7F, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h02, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
		// three header bytes, then the end
		'{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h02, 1'b1, 1'b1, 16'd4, 1'b1},
		// kept TLV cut short inside its payload
		'{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h04, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h03, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h11, 1'b0, 1'b0, 16'd0, 1'b0},
		'{8'h22, 1'b1, 1'b0, 16'd0, 1'b0},
		// list of a single byte, ends inside the first header
		'{8'h05, 1'b1, 1'b1, 16'd4, 1'b1}
	};

	oxm_tlv_field_strip u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.out_value    (out_value),
		.is_length    (is_length),
		.run_last     (run_last),
		.truncated    (truncated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.target_field (target_field)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(12 * 1000000);
		$display("FAILED: results differ");
		$finish;
	end

	// Work out the beats one accepted byte causes; leaves them in step_beats.
	function automatic void strip_step(input logic [7:0] b, input logic last);
		logic [16:0] len;
		item_t       beat;
		step_beats.delete();
		beat = '0;
		if (payload_rem != 8'd0) begin
			payload_rem = payload_rem - 8'd1;
			if (!skipping) begin
				beat.out_value = {8'h00, b};
				step_beats.push_back(beat);
				if (kept_total != 16'hFFFF) kept_total = kept_total + 16'd1;
			end
		end else begin
			hold_hdr[hdr_seen[1:0]] = b;
			hdr_seen = hdr_seen + 3'd1;
			if (hdr_seen == 3'd4) begin
				hdr_seen = 3'd0;
				skipping = (hold_hdr[2][7:1] == strip_field);
				if (!skipping) begin
					for (int i = 0; i < 4; i++) begin
						beat.out_value = {8'h00, hold_hdr[i]};
						step_beats.push_back(beat);
						if (kept_total != 16'hFFFF) kept_total = kept_total + 16'd1;
					end
				end
				payload_rem = hold_hdr[3];
			end
		end
		if (last) begin
			len = {1'b0, kept_total} + 17'd4;
			beat.out_value = (len > 17'h0FFFF) ? 16'hFFFF : len[15:0];
			beat.is_length = 1'b1;
			beat.truncated = (hdr_seen != 3'd0) || (payload_rem != 8'd0);
			step_beats.push_back(beat);
			hdr_seen = 3'd0;
			payload_rem = 8'd0;
			skipping = 1'b0;
			kept_total = 16'd0;
		end
		if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
	endfunction

	task automatic cmp_field(input string name, input logic [15:0] exp_v, input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Track config writes, predict accepted bytes, check popped beats.
	always @(posedge clk) begin
		item_t want;
		item_t typed;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) strip_field = target_field;
			if (push && !full) begin
				strip_step(data_byte, last_byte);
				typed = '0;
				typed.out_value = dir_len;
				typed.is_length = 1'b1;
				typed.run_last = 1'b1;
				typed.truncated = dir_trunc;
				// a typed row stands in for the length beat that closes the step
				foreach (step_beats[i]) begin
					if (dir_chk && (i == step_beats.size() - 1))
						beats_due.push_back(typed);
					else
						beats_due.push_back(step_beats[i]);
				end
			end
			if (pop && !empty) begin
				if (beats_due.size() == 0) begin
					$error("unexpected beat: out_value %0h is_length %0b", out_value, is_length);
					errors++;
				end else begin
					want = beats_due.pop_front();
					cmp_field("out_value", want.out_value, out_value);
					cmp_field("is_length", 16'(want.is_length), 16'(is_length));
					cmp_field("run_last", 16'(want.run_last), 16'(run_last));
					cmp_field("truncated", 16'(want.truncated), 16'(truncated));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) pop <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one byte, with a random idle gap ahead of it; hold until accepted.
	task automatic send_byte(input logic [7:0] b, input logic l, input logic chk,
			input logic [15:0] len, input logic tr);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		dir_chk <= chk;
		dir_len <= len;
		dir_trunc <= tr;
		do @(posedge clk); while (full);
	endtask

	// Let the checker take in the last accepted beat before watching the queue.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (beats_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_target(input logic [6:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		target_field <= v;
		cur_target = v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Build a random TLV list into list_bytes; some lists are cut short.
	task automatic build_list();
		int         n_tlv;
		logic [6:0] fld;
		logic [7:0] plen;
		list_bytes.delete();
		n_tlv = $urandom_range(1, 2);
		repeat (n_tlv) begin
			fld = $urandom_range(1) ? cur_target : 7'($urandom_range(127));
			plen = ($urandom_range(9) == 0) ? 8'($urandom_range(6, 20)) : 8'($urandom_range(5));
			list_bytes.push_back(8'($urandom_range(255)));
			list_bytes.push_back(8'($urandom_range(255)));
			list_bytes.push_back({fld, 1'($urandom_range(1))});
			list_bytes.push_back(plen);
			repeat (plen) list_bytes.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(99) < 15 && list_bytes.size() > 1)
			list_bytes = list_bytes[0:$urandom_range(0, list_bytes.size() - 2)];
	endtask

	initial begin
		int         sent;
		bit         held;
		int         gaps [4];
		int         stalls [4];
		logic [6:0] targets [4];

		gaps = '{0, 56, 0, 30};
		stalls = '{0, 0, 56, 30};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].chk,
				dir_rows[i].len, dir_rows[i].trunc);

		targets = '{7'd0, 7'($urandom_range(1, 126)), 7'd127, 7'($urandom_range(127))};
		for (int ph = 0; ph < 4; ph++) begin
			write_target(targets[ph]);
			gap_pct = gaps[ph];
			stall_pct = stalls[ph];
			sent = 0;
			held = 1'b0;
			while (sent < 15) begin
				build_list();
				foreach (list_bytes[i]) begin
					// hold off mid-list once per phase until the output side has caught up
					if (!held && i == list_bytes.size() / 2) begin
						wait_drained();
						held = 1'b1;
					end
					send_byte(list_bytes[i], (i == list_bytes.size() - 1), 1'b0, 16'd0, 1'b0);
					sent++;
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
